@@ design/fcpo_pkg.sv @@
`default_nettype none
// ============================================================================
// fcpo_pkg
// Shared types and constants of the pixel output stage: action and register
// codes, screen-mode and raster-mode encodings, palette write word.
// ============================================================================
package fcpo_pkg;

    // Fixed field widths
    localparam int COORD_W     = 7;
    localparam int PIX_W       = 4;
    localparam int BYTE_W      = 8;
    localparam int PAL_ENTRIES = 16;
    localparam int CFG_IDX_W   = 3;

    // Input item actions
    typedef enum logic [2:0] {
        ACT_READ       = 3'd0,
        ACT_FRAME      = 3'd1,
        ACT_OVERLAY    = 3'd2,
        ACT_SCREEN_PAL = 3'd3,
        ACT_RASTER_PAL = 3'd4,
        ACT_RASTER_BIT = 3'd5
    } action_t;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DISP_MODE      = 3'd0,
        CFG_RASTER_MODE    = 3'd1,
        CFG_OVERLAY_ENABLE = 3'd2,
        CFG_BOX_LEFT       = 3'd3,
        CFG_BOX_TOP        = 3'd4,
        CFG_BOX_RIGHT      = 3'd5,
        CFG_BOX_BOTTOM     = 3'd6
    } cfg_index_t;

    // Screen mode decoding
    localparam logic [7:0] ROT_MASK  = 8'hbc;
    localparam logic [7:0] ROT_CODE  = 8'h84;
    localparam logic [7:0] X_MASK    = 8'hbd;
    localparam logic [7:0] X_MIRROR  = 8'h05;
    localparam logic [7:0] X_STRETCH = 8'h01;
    localparam logic [7:0] X_FLIP    = 8'h81;
    localparam logic [7:0] Y_MASK    = 8'hbe;
    localparam logic [7:0] Y_MIRROR  = 8'h06;
    localparam logic [7:0] Y_STRETCH = 8'h02;
    localparam logic [7:0] Y_FLIP    = 8'h82;

    // Raster mode decoding and output mask
    localparam logic [7:0] RASTER_ALT       = 8'h10;
    localparam logic [7:0] RASTER_GRAD_MASK = 8'h30;
    localparam logic [7:0] COLOR_MASK       = 8'h8f;

    // Palette write word from pipeline stage 3
    typedef struct packed {
        logic              scr_we;
        logic              ras_we;
        logic [PIX_W-1:0]  pal_idx;
        logic [BYTE_W-1:0] data;
    } pal_wr_t;

endpackage
`default_nettype wire

@@ design/fcpo_xform.sv @@
`default_nettype none
// ============================================================================
// fcpo_xform
// Screen-mode coordinate transform: rotation, mirror, stretch and flip of a
// display position into a framebuffer position.
// ============================================================================
module fcpo_xform #(
    parameter int SCREEN_SIDE = 128,
    parameter int CW          = $clog2(SCREEN_SIDE)
) (
    input  wire logic [7:0]    disp_mode,
    input  wire logic [CW-1:0] x,
    input  wire logic [CW-1:0] y,
    output logic      [CW-1:0] sx,
    output logic      [CW-1:0] sy
);

    localparam logic [CW-1:0] TOP = CW'(SCREEN_SIDE - 1);

    // Fold the upper half of an axis back onto the lower half
    function automatic logic [CW-1:0] mirror_lo(input logic [CW-1:0] v);
        logic [CW-1:0] w;
        w = TOP - v;
        return (v < w) ? v : w;
    endfunction

    logic [7:0] mx;
    logic [7:0] my;

    assign mx = disp_mode & fcpo_pkg::X_MASK;
    assign my = disp_mode & fcpo_pkg::Y_MASK;

    // Pick rotation or the per-axis transforms
    always_comb
    begin
        logic [CW-1:0] tx;
        logic [CW-1:0] ty;
        tx = x;
        ty = y;
        if ((disp_mode & fcpo_pkg::ROT_MASK) == fcpo_pkg::ROT_CODE)
        begin
            if (disp_mode[0])
            begin
                tx = y;
                ty = x;
            end
            if (disp_mode[1])
            begin
                tx = TOP - tx;
            end
            // bit 1 of mode + 1
            if (disp_mode[1] ^ disp_mode[0])
            begin
                ty = TOP - ty;
            end
        end
        else
        begin
            if (mx == fcpo_pkg::X_MIRROR)
            begin
                tx = mirror_lo(x);
            end
            else if (mx == fcpo_pkg::X_STRETCH)
            begin
                tx = x >> 1;
            end
            else if (mx == fcpo_pkg::X_FLIP)
            begin
                tx = TOP - x;
            end
            if (my == fcpo_pkg::Y_MIRROR)
            begin
                ty = mirror_lo(y);
            end
            else if (my == fcpo_pkg::Y_STRETCH)
            begin
                ty = y >> 1;
            end
            else if (my == fcpo_pkg::Y_FLIP)
            begin
                ty = TOP - y;
            end
        end
        sx = tx;
        sy = ty;
    end

endmodule
`default_nettype wire

@@ design/fcpo_shade.sv @@
`default_nettype none
// ============================================================================
// fcpo_shade
// Screen and raster palettes with the shading select: alternate palette,
// gradient palette or screen palette, masked to the legal color bits.
// ============================================================================
module fcpo_shade (
    input  wire logic                               clk,
    input  wire logic [7:0]                         raster_mode,
    input  wire fcpo_pkg::pal_wr_t                  pal_wr,
    input  wire logic [fcpo_pkg::PIX_W-1:0]         pixel,
    input  wire logic                               rbit,
    input  wire logic [fcpo_pkg::PIX_W-1:0]         grad,
    output logic      [fcpo_pkg::BYTE_W-1:0]        color
);

    logic [fcpo_pkg::BYTE_W-1:0] scr_pal_reg [fcpo_pkg::PAL_ENTRIES];
    logic [fcpo_pkg::BYTE_W-1:0] ras_pal_reg [fcpo_pkg::PAL_ENTRIES];

    logic                        use_ras;
    logic [fcpo_pkg::PIX_W-1:0]  pal_sel;
    logic [fcpo_pkg::PIX_W-1:0]  grad_idx;
    logic [fcpo_pkg::BYTE_W-1:0] entry;

    // Write palette entries
    always_ff @(posedge clk)
    begin
        if (pal_wr.scr_we)
        begin
            scr_pal_reg[pal_wr.pal_idx] <= pal_wr.data;
        end
        if (pal_wr.ras_we)
        begin
            ras_pal_reg[pal_wr.pal_idx] <= pal_wr.data;
        end
    end

    // Gradient index wraps within the palette
    assign grad_idx = grad + fcpo_pkg::PIX_W'(rbit);

    // Select palette and entry
    always_comb
    begin
        use_ras = 1'b0;
        pal_sel = pixel;
        if (raster_mode == fcpo_pkg::RASTER_ALT)
        begin
            use_ras = rbit;
        end
        else if ((raster_mode & fcpo_pkg::RASTER_GRAD_MASK) == fcpo_pkg::RASTER_GRAD_MASK)
        begin
            if (raster_mode[3:0] == pixel)
            begin
                use_ras = 1'b1;
                pal_sel = grad_idx;
            end
        end
    end

    assign entry = use_ras ? ras_pal_reg[pal_sel] : scr_pal_reg[pal_sel];
    assign color = entry & fcpo_pkg::COLOR_MASK;

endmodule
`default_nettype wire

@@ design/fantasy_console_pixel_output_stage_top.sv @@
`default_nettype none
// ============================================================================
// fantasy_console_pixel_output_stage_top
// Display output stage: framebuffer, overlay buffer, palettes and raster row
// bits, with a four-stage read pipeline that shades one display pixel.
// ============================================================================
// Accepts one word per clock and returns one shaded pixel per clock for read
// words while the output is not held by out_ready; write words give no
// result. A read word passes coordinate wrap and input register, transform and
// address, the synchronous buffer read port, then palette shading into the
// output register. Each stage stalls only when the stage ahead is full, so
// input is still taken while a result waits if a bubble is in the pipeline.
// Writes take effect in program order for every later read. Buffers and
// palettes need no clearing after reset; raster row bits read as zero until
// written.
module fantasy_console_pixel_output_stage_top #(
    parameter int SCREEN_SIDE = 128
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    // Configuration port
    input  wire logic                                  cfg_we,
    input  wire logic [fcpo_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [fcpo_pkg::BYTE_W-1:0]           cfg_data,
    // Input channel
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [2:0]                            action,
    input  wire logic [fcpo_pkg::COORD_W-1:0]          col,
    input  wire logic [fcpo_pkg::COORD_W-1:0]          row,
    input  wire logic [fcpo_pkg::PIX_W-1:0]            pal_index,
    input  wire logic [fcpo_pkg::BYTE_W-1:0]           value,
    // Output channel
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output logic      [fcpo_pkg::BYTE_W-1:0]           color,
    output logic                                       from_overlay
);

    localparam int CW         = $clog2(SCREEN_SIDE);
    localparam int CELLS      = SCREEN_SIDE * SCREEN_SIDE;
    localparam int AW         = $clog2(CELLS);
    localparam int SPAN       = 2 ** fcpo_pkg::COORD_W;
    localparam int WRAP_STEPS = (SPAN + SCREEN_SIDE - 1) / SCREEN_SIDE - 1;

    // Reduce a field coordinate into the screen
    function automatic logic [CW-1:0] wrap(input logic [fcpo_pkg::COORD_W-1:0] v);
        logic [8:0] t;
        t = 9'(v);
        for (int i = 0; i < WRAP_STEPS; i++)
        begin
            if (t >= 9'(SCREEN_SIDE))
            begin
                t = t - 9'(SCREEN_SIDE);
            end
        end
        return CW'(t);
    endfunction

    // Configuration registers
    logic [7:0] disp_mode_reg;
    logic [7:0] raster_mode_reg;
    logic       overlay_enable_reg;
    logic [7:0] box_left_reg;
    logic [7:0] box_top_reg;
    logic [7:0] box_right_reg;
    logic [7:0] box_bottom_reg;

    // Stage handshake
    logic ld1;
    logic ld2;
    logic ld3;
    logic ld_out;

    // Stage 1
    logic                        s1_v_reg;
    logic [2:0]                  s1_act_reg;
    logic [CW-1:0]               s1_x_reg;
    logic [CW-1:0]               s1_y_reg;
    logic [fcpo_pkg::PIX_W-1:0]  s1_pidx_reg;
    logic [fcpo_pkg::BYTE_W-1:0] s1_val_reg;

    // Stage 2
    logic                        s2_v_reg;
    logic [2:0]                  s2_act_reg;
    logic [AW-1:0]               s2_addr_reg;
    logic [CW-1:0]               s2_row_reg;
    logic                        s2_ovl_reg;
    logic [fcpo_pkg::PIX_W-1:0]  s2_pidx_reg;
    logic [fcpo_pkg::BYTE_W-1:0] s2_val_reg;
    logic [AW-1:0]               s2_addr_next;
    logic [CW-1:0]               s2_row_next;
    logic                        s2_ovl_next;

    // Stage 3
    logic                        s3_v_reg;
    logic [2:0]                  s3_act_reg;
    logic [CW-1:0]               s3_row_reg;
    logic                        s3_ovl_reg;
    logic [fcpo_pkg::PIX_W-1:0]  s3_pidx_reg;
    logic [fcpo_pkg::BYTE_W-1:0] s3_val_reg;
    logic [fcpo_pkg::PIX_W-1:0]  s3_fpix_reg;
    logic [fcpo_pkg::PIX_W-1:0]  s3_opix_reg;
    logic                        s3_rbit_reg;
    logic                        s3_rvalid_reg;

    // Output register
    logic                        out_valid_reg;
    logic [fcpo_pkg::BYTE_W-1:0] color_reg;
    logic                        from_overlay_reg;
    logic [fcpo_pkg::BYTE_W-1:0] color_next;

    // Memories and raster row valid bits
    logic [fcpo_pkg::PIX_W-1:0] frame_mem   [CELLS];
    logic [fcpo_pkg::PIX_W-1:0] overlay_mem [CELLS];
    logic                       rast_mem    [SCREEN_SIDE];
    logic [SCREEN_SIDE-1:0]     rast_valid_reg;

    // Stage 1 combinational
    logic          s1_read;
    logic          s1_hit;
    logic          s1_use_src;
    logic [CW-1:0] s1_sx;
    logic [CW-1:0] s1_sy;
    logic [CW-1:0] s1_ax;
    logic [CW-1:0] s1_ay;
    logic [7:0]    s1_x8;
    logic [7:0]    s1_y8;

    // Stage 3 combinational
    logic                        s3_read;
    logic [fcpo_pkg::PIX_W-1:0]  s3_pix;
    logic                        s3_rbit;
    logic [7:0]                  s3_row8;
    fcpo_pkg::pal_wr_t           pal_wr;

    // ------------------------------------------------------------------
    // Configuration writes
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_mode_reg      <= '0;
            raster_mode_reg    <= '0;
            overlay_enable_reg <= 1'b0;
            box_left_reg       <= '0;
            box_top_reg        <= '0;
            box_right_reg      <= '0;
            box_bottom_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fcpo_pkg::CFG_DISP_MODE:      disp_mode_reg      <= cfg_data;
                fcpo_pkg::CFG_RASTER_MODE:    raster_mode_reg    <= cfg_data;
                fcpo_pkg::CFG_OVERLAY_ENABLE: overlay_enable_reg <= cfg_data[0];
                fcpo_pkg::CFG_BOX_LEFT:       box_left_reg       <= cfg_data;
                fcpo_pkg::CFG_BOX_TOP:        box_top_reg        <= cfg_data;
                fcpo_pkg::CFG_BOX_RIGHT:      box_right_reg      <= cfg_data;
                fcpo_pkg::CFG_BOX_BOTTOM:     box_bottom_reg     <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Stage advance: a stage loads when it is empty or its word moves on
    // ------------------------------------------------------------------
    assign s3_read  = (s3_act_reg == fcpo_pkg::ACT_READ);
    assign ld_out   = !out_valid_reg || out_ready;
    assign ld3      = !s3_v_reg || !s3_read || ld_out;
    assign ld2      = !s2_v_reg || ld3;
    assign ld1      = !s1_v_reg || ld2;
    assign in_ready = ld1;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            s3_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (ld1)
            begin
                s1_v_reg <= in_valid;
            end
            if (ld2)
            begin
                s2_v_reg <= s1_v_reg;
            end
            if (ld3)
            begin
                s3_v_reg <= s2_v_reg;
            end
            if (ld_out)
            begin
                out_valid_reg <= s3_v_reg && s3_read;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: wrap coordinates and register the word
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ld1)
        begin
            s1_act_reg  <= action;
            s1_x_reg    <= wrap(col);
            s1_y_reg    <= wrap(row);
            s1_pidx_reg <= pal_index;
            s1_val_reg  <= value;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1 -> 2: overlay box test, transform, cell address
    // ------------------------------------------------------------------
    fcpo_xform #(
        .SCREEN_SIDE (SCREEN_SIDE),
        .CW          (CW)
    ) u_xform (
        .disp_mode   (disp_mode_reg),
        .x           (s1_x_reg),
        .y           (s1_y_reg),
        .sx          (s1_sx),
        .sy          (s1_sy)
    );

    assign s1_x8      = 8'(s1_x_reg);
    assign s1_y8      = 8'(s1_y_reg);
    assign s1_read    = (s1_act_reg == fcpo_pkg::ACT_READ);
    assign s1_hit     = overlay_enable_reg
                        && (s1_x8 >= box_left_reg) && (s1_x8 <= box_right_reg)
                        && (s1_y8 >= box_top_reg) && (s1_y8 <= box_bottom_reg);
    assign s1_use_src = s1_read && !s1_hit;
    assign s1_ax      = s1_use_src ? s1_sx : s1_x_reg;
    assign s1_ay      = s1_use_src ? s1_sy : s1_y_reg;

    assign s2_addr_next = AW'(s1_ay) * AW'(SCREEN_SIDE) + AW'(s1_ax);
    assign s2_row_next  = s1_ay;
    assign s2_ovl_next  = s1_read && s1_hit;

    always_ff @(posedge clk)
    begin
        if (ld2)
        begin
            s2_act_reg  <= s1_act_reg;
            s2_addr_reg <= s2_addr_next;
            s2_row_reg  <= s2_row_next;
            s2_ovl_reg  <= s2_ovl_next;
            s2_pidx_reg <= s1_pidx_reg;
            s2_val_reg  <= s1_val_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2 -> 3: buffer and raster memories, written and read in order
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            if (s2_v_reg && (s2_act_reg == fcpo_pkg::ACT_FRAME))
            begin
                frame_mem[s2_addr_reg] <= s2_val_reg[fcpo_pkg::PIX_W-1:0];
            end
            if (s2_v_reg && (s2_act_reg == fcpo_pkg::ACT_OVERLAY))
            begin
                overlay_mem[s2_addr_reg] <= s2_val_reg[fcpo_pkg::PIX_W-1:0];
            end
            if (s2_v_reg && (s2_act_reg == fcpo_pkg::ACT_RASTER_BIT))
            begin
                rast_mem[s2_row_reg] <= s2_val_reg[0];
            end
            s3_fpix_reg <= frame_mem[s2_addr_reg];
            s3_opix_reg <= overlay_mem[s2_addr_reg];
            s3_rbit_reg <= rast_mem[s2_row_reg];
        end
    end

    // Mark raster rows once written; unwritten rows read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rast_valid_reg <= '0;
        end
        else if (ld3 && s2_v_reg && (s2_act_reg == fcpo_pkg::ACT_RASTER_BIT))
        begin
            rast_valid_reg[s2_row_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld3)
        begin
            s3_act_reg    <= s2_act_reg;
            s3_row_reg    <= s2_row_reg;
            s3_ovl_reg    <= s2_ovl_reg;
            s3_pidx_reg   <= s2_pidx_reg;
            s3_val_reg    <= s2_val_reg;
            s3_rvalid_reg <= rast_valid_reg[s2_row_reg];
        end
    end

    // ------------------------------------------------------------------
    // Stage 3 -> output: palette writes and shading
    // ------------------------------------------------------------------
    assign s3_pix  = s3_ovl_reg ? s3_opix_reg : s3_fpix_reg;
    assign s3_rbit = s3_rvalid_reg && s3_rbit_reg;
    assign s3_row8 = 8'(s3_row_reg);

    assign pal_wr.scr_we  = s3_v_reg && ld3 && (s3_act_reg == fcpo_pkg::ACT_SCREEN_PAL);
    assign pal_wr.ras_we  = s3_v_reg && ld3 && (s3_act_reg == fcpo_pkg::ACT_RASTER_PAL);
    assign pal_wr.pal_idx = s3_pidx_reg;
    assign pal_wr.data    = s3_val_reg;

    fcpo_shade u_shade (
        .clk         (clk),
        .raster_mode (raster_mode_reg),
        .pal_wr      (pal_wr),
        .pixel       (s3_pix),
        .rbit        (s3_rbit),
        .grad        (s3_row8[6:3]),
        .color       (color_next)
    );

    always_ff @(posedge clk)
    begin
        if (ld_out)
        begin
            color_reg        <= color_next;
            from_overlay_reg <= s3_ovl_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign color        = color_reg;
    assign from_overlay = from_overlay_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> in_ready)
        else $error("input not ready with an empty output register");

    a_color_masked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((color_reg & ~fcpo_pkg::COLOR_MASK) == 8'h00))
        else $error("color carries bits outside the mask");

    a_stage3_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s3_v_reg && !ld3) |=> (s3_v_reg && $stable(s3_row_reg) && $stable(s3_fpix_reg)))
        else $error("stalled read word changed in stage 3");

    a_raster_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (ld3 && s2_v_reg && (s2_act_reg == fcpo_pkg::ACT_RASTER_BIT))
        |=> rast_valid_reg[$past(s2_row_reg)])
        else $error("raster row write not marked valid");

endmodule
`default_nettype wire
